// ===== hw/rtl/ffba_pkg.sv =====
// shared widths, codes and defaults of the first-fit block allocator
package ffba_pkg;
   localparam int PoolWordsDefault = 1024;
   localparam int CfgResetWords = 1024;
   localparam int SizeW = 11;
   localparam int HdrW = SizeW + 1;
   localparam int IdxW = 12;
   localparam int OffW = 10;
   localparam int CmdW = 2;
   localparam int StatW = 2;

   localparam logic [CmdW-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CmdW-1:0] CMD_FREE  = 2'd1;
   localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

   localparam logic [StatW-1:0] STAT_OK     = 2'd0;
   localparam logic [StatW-1:0] STAT_NOFIT  = 2'd1;
   localparam logic [StatW-1:0] STAT_ZERO   = 2'd2;
   localparam logic [StatW-1:0] STAT_NOTALC = 2'd3;
endpackage

// ===== hw/rtl/ffba_ram.sv =====
// generic simple dual-port ram with registered read
module ffba_ram #(
   parameter int Width = 12,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// first-fit allocator over an implicit header list held in one ram
//
// usage: items enter on req_valid/req_ready with a command (allocate, free,
// query largest free run) and leave as one result on rsp_valid/rsp_ready.
// csr_we with csr_wdata sets the pool size (clamped to 3..POOL_WORDS) and
// reformats the pool.
// allocate and query read each header in ST_RD and evaluate it in
// ST_EVAL; H, the number of headers visited, stays below pool_words/2+1.
// a free passes ST_FRD and ST_FEVAL, a zero request or unused command goes
// straight to ST_DONE, and a split allocate adds ST_SPLIT to write its own
// header. no new item is taken until the block is back in ST_IDLE.
// reset and every csr write start a clearing pass that writes each header
// word of the pool once; no item is taken meanwhile.
// the result sits in an output register: the next item is taken while it
// waits, and a finished item whose result cannot be posted holds in place
// until rsp_ready frees the register.
module first_fit_block_allocator #(
   parameter int POOL_WORDS = ffba_pkg::PoolWordsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ffba_pkg::CmdW-1:0]   req_command,
   input  logic [ffba_pkg::SizeW-1:0]  req_request_words,
   input  logic [ffba_pkg::OffW-1:0]   req_payload_offset,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ffba_pkg::StatW-1:0]  rsp_status,
   output logic [ffba_pkg::OffW-1:0]   rsp_block_offset,
   output logic [ffba_pkg::OffW-1:0]   rsp_largest_free_words,
   input  logic                        csr_we,
   input  logic [ffba_pkg::SizeW-1:0]  csr_wdata
);
   localparam int AW = $clog2(POOL_WORDS);
   localparam int SW = ffba_pkg::SizeW;
   localparam int HW = ffba_pkg::HdrW;
   localparam int IW = ffba_pkg::IdxW;
   localparam int OW = ffba_pkg::OffW;
   localparam int RstWords = (POOL_WORDS < ffba_pkg::CfgResetWords) ?
                             POOL_WORDS : ffba_pkg::CfgResetWords;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_EVAL  = 3'd3;
   localparam logic [2:0] ST_SPLIT = 3'd4;
   localparam logic [2:0] ST_FRD   = 3'd5;
   localparam logic [2:0] ST_FEVAL = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [SW-1:0] pool_ff, pool_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] run_ff, run_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] best_ff, best_in;
   logic [SW-1:0] need_ff, need_in;
   logic          alloc_ff, alloc_in;
   logic [ffba_pkg::StatW-1:0] res_stat_ff, res_stat_in;
   logic [OW-1:0] res_blk_ff, res_blk_in;
   logic [OW-1:0] res_lrg_ff, res_lrg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [ffba_pkg::StatW-1:0] rsp_stat_ff, rsp_stat_in;
   logic [OW-1:0] rsp_blk_ff, rsp_blk_in;
   logic [OW-1:0] rsp_lrg_ff, rsp_lrg_in;

   logic          wr_en;
   logic [IW-1:0] wr_idx;
   logic [HW-1:0] wr_data;
   logic [HW-1:0] rd_data;

   logic [IW-1:0] pool_x, pool_m1, sz, nxt, run_new, start_new, remain, off_m1;
   logic          hdr_flag;

   ffba_ram #(.Width(HW), .Depth(POOL_WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(wr_idx)),
      .wr_data (wr_data),
      .rd_addr (AW'(idx_ff)),
      .rd_data (rd_data)
   );

   assign pool_x    = IW'(pool_ff);
   assign pool_m1   = pool_x - IW'(1);
   assign hdr_flag  = rd_data[HW-1];
   assign sz        = IW'(rd_data[SW-1:0]);
   assign nxt       = idx_ff + IW'(1) + sz;
   assign run_new   = (run_ff == '0) ? sz : (run_ff + IW'(1) + sz);
   assign start_new = (run_ff == '0) ? idx_ff : start_ff;
   assign remain    = run_new - IW'(need_ff);
   assign off_m1    = IW'(req_payload_offset) - IW'(1);

   always_comb begin
      if (csr_wdata < SW'(3)) begin
         pool_in = SW'(3);
      end else if (int'(csr_wdata) > POOL_WORDS) begin
         pool_in = SW'(POOL_WORDS);
      end else begin
         pool_in = csr_wdata;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      idx_in      = idx_ff;
      run_in      = run_ff;
      start_in    = start_ff;
      best_in     = best_ff;
      need_in     = need_ff;
      alloc_in    = alloc_ff;
      res_stat_in = res_stat_ff;
      res_blk_in  = res_blk_ff;
      res_lrg_in  = res_lrg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stat_in = rsp_stat_ff;
      rsp_blk_in  = rsp_blk_ff;
      rsp_lrg_in  = rsp_lrg_ff;
      wr_en       = 1'b0;
      wr_idx      = '0;
      wr_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_stat_in = ffba_pkg::STAT_OK;
               res_blk_in  = '0;
               res_lrg_in  = '0;
               idx_in      = '0;
               run_in      = '0;
               start_in    = '0;
               best_in     = '0;
               need_in     = req_request_words;
               state_in    = ST_DONE;
               unique case (req_command)
                  ffba_pkg::CMD_ALLOC: begin
                     if (req_request_words == '0) begin
                        res_stat_in = ffba_pkg::STAT_ZERO;
                     end else begin
                        alloc_in = 1'b1;
                        state_in = ST_RD;
                     end
                  end
                  ffba_pkg::CMD_FREE: begin
                     if (req_payload_offset == '0 || off_m1 >= pool_m1) begin
                        res_stat_in = ffba_pkg::STAT_NOTALC;
                     end else begin
                        idx_in   = off_m1;
                        state_in = ST_FRD;
                     end
                  end
                  ffba_pkg::CMD_QUERY: begin
                     alloc_in = 1'b0;
                     state_in = ST_RD;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // word 0 gets the single free block, everything else is zeroed
            wr_en   = 1'b1;
            wr_idx  = IW'(clr_ff);
            wr_data = (clr_ff == '0) ? HW'(pool_ff - SW'(2)) : '0;
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == pool_ff - SW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            // each header step advances at least two words, so the walk needs no step limit
            if (idx_ff >= pool_x) begin
               res_stat_in = alloc_ff ? ffba_pkg::STAT_NOFIT : ffba_pkg::STAT_OK;
               res_lrg_in  = alloc_ff ? '0 : best_ff[OW-1:0];
               state_in    = ST_DONE;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sz == '0 || nxt > pool_m1) begin
               res_stat_in = alloc_ff ? ffba_pkg::STAT_NOFIT : ffba_pkg::STAT_OK;
               res_lrg_in  = alloc_ff ? '0 : best_ff[OW-1:0];
               state_in    = ST_DONE;
            end else if (!hdr_flag) begin
               run_in   = run_new;
               start_in = start_new;
               if (run_new > best_ff) begin
                  best_in = run_new;
               end
               if (alloc_ff && run_new >= IW'(need_ff)) begin
                  res_blk_in = OW'(start_new + IW'(1));
                  wr_en      = 1'b1;
                  if (remain >= IW'(2)) begin
                     // remainder header first, own header next cycle
                     wr_idx   = start_new + IW'(1) + IW'(need_ff);
                     wr_data  = HW'(remain - IW'(1));
                     state_in = ST_SPLIT;
                  end else begin
                     wr_idx   = start_new;
                     wr_data  = {1'b1, run_new[SW-1:0]};
                     state_in = ST_DONE;
                  end
               end else begin
                  idx_in   = nxt;
                  state_in = ST_RD;
               end
            end else begin
               run_in   = '0;
               idx_in   = nxt;
               state_in = ST_RD;
            end
         end
         ST_SPLIT: begin
            wr_en    = 1'b1;
            wr_idx   = start_ff;
            wr_data  = {1'b1, need_ff};
            state_in = ST_DONE;
         end
         ST_FRD: begin
            state_in = ST_FEVAL;
         end
         ST_FEVAL: begin
            if (hdr_flag) begin
               wr_en   = 1'b1;
               wr_idx  = idx_ff;
               wr_data = {1'b0, rd_data[SW-1:0]};
            end else begin
               res_stat_in = ffba_pkg::STAT_NOTALC;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_blk_in   = res_blk_ff;
               rsp_lrg_in   = res_lrg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pool_ff      <= SW'(RstWords);
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         alloc_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         alloc_ff     <= alloc_in;
         if (csr_we) begin
            pool_ff <= pool_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      best_ff     <= best_in;
      need_ff     <= need_in;
      res_stat_ff <= res_stat_in;
      res_blk_ff  <= res_blk_in;
      res_lrg_ff  <= res_lrg_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_lrg_ff  <= rsp_lrg_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_stat_ff;
   assign rsp_block_offset       = rsp_blk_ff;
   assign rsp_largest_free_words = rsp_lrg_ff;

   // no item is taken while the pool is being reformatted
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("item accepted during clearing pass");

   // a new result only appears out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result posted outside done state");

   // header writes outside the clearing pass stay inside the pool
   a_wr_in_pool: assert property (@(posedge clock) disable iff (reset)
      wr_en && state_ff != ST_CLEAR |-> wr_idx < pool_x)
      else $error("header write beyond end mark");

   // a split always follows a fitting evaluation
   a_split_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SPLIT |-> $past(state_ff == ST_EVAL) && alloc_ff)
      else $error("split without fitting run");
endmodule

// ===== sim/tb_first_fit_block_allocator.sv =====
// self-checking testbench for the first-fit block allocator
module tb_first_fit_block_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PoolMax = 1024;
   localparam int StallLimit = 20000;
   localparam int CmdW = ffba_pkg::CmdW;
   localparam int SizeW = ffba_pkg::SizeW;
   localparam int HdrW = ffba_pkg::HdrW;
   localparam int OffW = ffba_pkg::OffW;
   localparam int StatW = ffba_pkg::StatW;
   localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic [OffW-1:0]  block_offset;
      logic [OffW-1:0]  largest_free_words;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CmdW-1:0] req_command = ffba_pkg::CMD_QUERY;
   logic [SizeW-1:0] req_request_words = '0;
   logic [OffW-1:0] req_payload_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [StatW-1:0] rsp_status;
   logic [OffW-1:0] rsp_block_offset;
   logic [OffW-1:0] rsp_largest_free_words;
   logic csr_we = 1'b0;
   logic [SizeW-1:0] csr_wdata = '0;

   // bit 11 allocated flag, bits 10:0 payload size
   logic [HdrW-1:0] hdr_words [PoolMax];
   int pool_words;
   alloc_result_type pending_results[$];
   int live_blocks[$];
   int errors = 0;
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   int hold_len = 0;
   int quiet_cycles = 0;

   first_fit_block_allocator #(.POOL_WORDS(PoolMax)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_request_words(req_request_words),
      .req_payload_offset(req_payload_offset),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_block_offset(rsp_block_offset),
      .rsp_largest_free_words(rsp_largest_free_words),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void format_pool();
      for (int i = 0; i < PoolMax; i++) hdr_words[i] = '0;
      hdr_words[0] = HdrW'(pool_words - 2);
      live_blocks.delete();
   endfunction

   // first-fit walk; claims a run when claim is set, else returns largest run
   function automatic int walk_chain(bit claim, int need);
      int idx = 0, run = 0, start = 0, best = 0, sz, nxt;
      for (int s = 0; s < PoolMax; s++) begin
         if (idx >= pool_words) break;
         sz = int'(hdr_words[idx][SizeW-1:0]);
         if (sz == 0) break;
         nxt = idx + 1 + sz;
         if (nxt > pool_words - 1) break;
         if (!hdr_words[idx][SizeW]) begin
            if (run == 0) begin
               start = idx;
               run = sz;
            end else begin
               run += 1 + sz;
            end
            if (run > best) best = run;
            if (claim && run >= need) begin
               if (run - need >= 2) begin
                  hdr_words[start + 1 + need] = {1'b0, SizeW'(run - need - 1)};
                  hdr_words[start] = {1'b1, SizeW'(need)};
               end else begin
                  hdr_words[start] = {1'b1, SizeW'(run)};
               end
               return start + 1;
            end
         end else begin
            run = 0;
         end
         idx = nxt;
      end
      return claim ? 0 : best;
   endfunction

   function automatic alloc_result_type predict_result(logic [CmdW-1:0] cmd, int words,
                                                       int off);
      alloc_result_type r = '0;
      int blk;
      case (cmd)
         ffba_pkg::CMD_ALLOC: begin
            if (words == 0) begin
               r.status = ffba_pkg::STAT_ZERO;
            end else begin
               blk = walk_chain(1'b1, words);
               r.block_offset = OffW'(blk);
               if (blk == 0) r.status = ffba_pkg::STAT_NOFIT;
               else live_blocks.push_back(blk);
            end
         end
         ffba_pkg::CMD_FREE: begin
            if (off == 0 || off - 1 >= pool_words - 1 || !hdr_words[off-1][SizeW]) begin
               r.status = ffba_pkg::STAT_NOTALC;
            end else begin
               hdr_words[off-1][SizeW] = 1'b0;
            end
         end
         ffba_pkg::CMD_QUERY: r.largest_free_words = OffW'(walk_chain(1'b0, 0));
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(logic [CmdW-1:0] cmd, int words, int off);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_command = cmd;
      req_request_words = SizeW'(words);
      req_payload_offset = OffW'(off);
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_result(cmd, words, off));
   endtask

   task automatic write_pool_words(int value);
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (8) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = SizeW'(value);
      @(negedge clock);
      csr_we = 1'b0;
      pool_words = (value < 3) ? 3 : (value > PoolMax) ? PoolMax : value;
      format_pool();
   endtask

   // mostly well-formed traffic: allocs, frees of live blocks, queries
   task automatic random_item(int max_req);
      int pick, k;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_item(ffba_pkg::CMD_ALLOC, $urandom_range(1, max_req), $urandom_range(0, 1023));
      end else if (pick < 80 && live_blocks.size() > 0) begin
         k = $urandom_range(0, live_blocks.size() - 1);
         send_item(ffba_pkg::CMD_FREE, $urandom_range(0, 2047), live_blocks[k]);
         live_blocks.delete(k);
      end else if (pick < 90) begin
         send_item(ffba_pkg::CMD_QUERY, $urandom_range(0, 2047), $urandom_range(0, 1023));
      end else begin
         send_item(CmdW'($urandom_range(0, 3)), $urandom_range(0, 2047),
                   $urandom_range(0, 1023));
      end
   endtask

   task automatic test_directed();
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      send_item(ffba_pkg::CMD_ALLOC, 0, 0);
      send_item(ffba_pkg::CMD_ALLOC, 2047, 1023);
      send_item(ffba_pkg::CMD_ALLOC, 1024, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_ALLOC, 3, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_FREE, 0, 0);
      send_item(ffba_pkg::CMD_FREE, 0, 1023);
      send_item(ffba_pkg::CMD_FREE, 0, 5);
      send_item(ffba_pkg::CMD_FREE, 0, 3);
      send_item(ffba_pkg::CMD_FREE, 0, 2);
      send_item(ffba_pkg::CMD_FREE, 0, 2);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      // the only freed block holds three words, so this allocate passes it
      send_item(ffba_pkg::CMD_ALLOC, 5, 0);
      send_item(CMD_UNUSED, 2047, 1023);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      // a request above the largest free run is refused
      send_item(ffba_pkg::CMD_ALLOC, 1013, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
   endtask

   task automatic test_config_extremes();
      write_pool_words(0);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      send_item(ffba_pkg::CMD_ALLOC, 2, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_FREE, 0, 1);
      send_item(ffba_pkg::CMD_FREE, 0, 2);
      write_pool_words(4);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1, 0);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      write_pool_words(2047);
      send_item(ffba_pkg::CMD_QUERY, 0, 0);
      send_item(ffba_pkg::CMD_ALLOC, 1022, 0);
      send_item(ffba_pkg::CMD_FREE, 0, 1);
   endtask

   task automatic test_random_pools();
      int sz;
      for (int phase = 0; phase < 14; phase++) begin
         sz = (phase % 7 == 6) ? PoolMax : $urandom_range(3, 160);
         write_pool_words(sz);
         for (int n = 0; n < ((sz == PoolMax) ? 40 : 70); n++)
            random_item((phase % 3 == 0) ? sz : 12);
      end
   endtask

   task automatic test_backpressure();
      write_pool_words(64);
      @(negedge clock);
      hold_len = 400;
      hold_req = 1'b1;
      for (int n = 0; n < 20; n++) random_item(8);
   endtask

   task automatic test_no_idle();
      write_pool_words(96);
      idle_on = 1'b0;
      for (int n = 0; n < 200; n++) random_item(10);
   endtask

   // receiver side stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_ready = 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_req = 1'b0;
         end else if (idle_on && !reset && $urandom_range(0, 6) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_block_offset !== want.block_offset) begin
               $error("block_offset expected %0d actual %0d",
                      want.block_offset, rsp_block_offset);
               errors++;
            end
            if (rsp_largest_free_words !== want.largest_free_words) begin
               $error("largest_free_words expected %0d actual %0d",
                      want.largest_free_words, rsp_largest_free_words);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      pool_words = PoolMax;
      format_pool();
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_random_pools();
      test_backpressure();
      test_no_idle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_results.size() == 0);
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
